>>> rtl/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared clocking and reporting for the checker's properties.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check a property on every rising edge outside reset
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation codes and the per-cycle operation broadcast to the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  // Operation that the cell row performs this cycle, errors already screened out
  typedef struct packed {
    logic add_front;
    logic add_back;
    logic take_front;
    logic take_back;
    logic clear;
  } op_t;

endpackage

>>> rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// Double-ended queue cell
// One storage slot of the row; cell 0 holds the front entry. Entries shift
// towards the back on a front push and towards the front on a front pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  deq_pkg::op_t               op,
  input  logic [deq_pkg::DATA_W-1:0] push_value,
  input  logic [deq_pkg::DATA_W-1:0] left_data,
  input  logic                       left_occ,
  input  logic [deq_pkg::DATA_W-1:0] right_data,
  input  logic                       right_occ,
  output logic [deq_pkg::DATA_W-1:0] data,
  output logic                       occ,
  output logic [deq_pkg::DATA_W-1:0] tail_data
);
  import deq_pkg::*;

  logic [DATA_W-1:0] data_next;
  logic              occ_next;
  logic              is_tail;
  logic              is_gap;

  // Last occupied cell, and first free cell behind the occupied run
  assign is_tail = occ && !right_occ;
  assign is_gap  = !occ && left_occ;

  // Present this cell's entry when it is the back of the queue
  assign tail_data = is_tail ? data : '0;

  // Work out the slot's new content from the broadcast operation
  always_comb begin
    data_next = data;
    occ_next  = occ;
    priority if (op.clear) begin
      occ_next = 1'b0;
    end else if (op.add_front) begin
      data_next = left_data;
      occ_next  = left_occ;
    end else if (op.take_front) begin
      data_next = right_data;
      occ_next  = right_occ;
    end else if (op.add_back) begin
      if (is_gap) begin
        data_next = push_value;
        occ_next  = 1'b1;
      end
    end else if (op.take_back) begin
      if (is_tail) begin
        occ_next = 1'b0;
      end
    end else begin
      // Hold the slot
      data_next = data;
      occ_next  = occ;
    end
  end

  // Clear occupancy under reset; data needs none
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of DEPTH entries kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue takes one item per clock (push front, push back, pop front, pop
// back or clear) and returns one result per item, registered in the cycle after
// the item is accepted: the popped value, the error flags and the entry count
// after the operation. The cell row updates every slot in the same cycle;
// in_ready stays high while the result register is empty or being taken, so
// throughput drops only when out_ready is held low.
// A pop on an empty queue and a push on a full queue leave the contents alone
// and raise empty_error or full_error. Command codes above clear do nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [deq_pkg::CMD_W-1:0]  cmd,
  input  logic [deq_pkg::DATA_W-1:0] push_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [deq_pkg::DATA_W-1:0] pop_value,
  output logic                       empty_error,
  output logic                       full_error,
  output logic [deq_pkg::CNT_W-1:0]  entry_count
);
  import deq_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              accept;
  logic              full;
  logic              empty;
  op_t               op;
  logic              is_push;
  logic              is_pop;
  logic [DATA_W-1:0] tail_value;
  logic [DATA_W-1:0] pop_next;

  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_occ   [DEPTH];
  logic [DATA_W-1:0] cell_tail  [DEPTH];
  logic [DATA_W-1:0] left_data  [DEPTH];
  logic              left_occ   [DEPTH];
  logic [DATA_W-1:0] right_data [DEPTH];
  logic              right_occ  [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
  assign is_pop   = (cmd == CMD_POP_FRONT) || (cmd == CMD_POP_BACK);

  // Screen out rejected pushes and pops before broadcasting to the cells
  always_comb begin
    op.add_front  = accept && (cmd == CMD_PUSH_FRONT) && !full;
    op.add_back   = accept && (cmd == CMD_PUSH_BACK) && !full;
    op.take_front = accept && (cmd == CMD_POP_FRONT) && !empty;
    op.take_back  = accept && (cmd == CMD_POP_BACK) && !empty;
    op.clear      = accept && (cmd == CMD_CLEAR);
  end

  // Wire each cell to its neighbours; the row ends feed the new item and nothing
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_data[gi] = push_value;
        assign left_occ[gi]  = 1'b1;
      end else begin : g_inner_l
        assign left_data[gi] = cell_data[gi-1];
        assign left_occ[gi]  = cell_occ[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_data[gi] = '0;
        assign right_occ[gi]  = 1'b0;
      end else begin : g_inner_r
        assign right_data[gi] = cell_data[gi+1];
        assign right_occ[gi]  = cell_occ[gi+1];
      end

      deq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .op         (op),
        .push_value (push_value),
        .left_data  (left_data[gi]),
        .left_occ   (left_occ[gi]),
        .right_data (right_data[gi]),
        .right_occ  (right_occ[gi]),
        .data       (cell_data[gi]),
        .occ        (cell_occ[gi]),
        .tail_data  (cell_tail[gi])
      );
    end
  endgenerate

  // Gather the back entry; at most one cell presents a non-zero value
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_value = tail_value | cell_tail[i];
    end
  end

  // Select the popped value
  always_comb begin
    priority if (op.take_front) begin
      pop_next = cell_data[0];
    end else if (op.take_back) begin
      pop_next = tail_value;
    end else begin
      pop_next = '0;
    end
  end

  // Advance the entry count
  always_comb begin
    count_next = count;
    priority if (op.clear) begin
      count_next = '0;
    end else if (op.add_front || op.add_back) begin
      count_next = count + 1'b1;
    end else if (op.take_front || op.take_back) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result register with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_value   <= pop_next;
      empty_error <= is_pop && empty;
      full_error  <= is_push && full;
      entry_count <= count_next;
    end
  end

endmodule

>>> rtl/deq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level properties of the deque, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "double_ended_queue_assert.svh"

module deq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [deq_pkg::DATA_W-1:0] pop_value,
  input logic                       empty_error,
  input logic                       full_error,
  input logic [deq_pkg::CNT_W-1:0]  entry_count
);
  import deq_pkg::*;

  `DEQ_ASSERT(a_hold_result, out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(entry_count), "result changed while stalled")
  `DEQ_ASSERT(a_one_error, out_valid |-> !(empty_error && full_error), "both error flags set")
  `DEQ_ASSERT(a_full_count, out_valid && full_error |-> entry_count == CNT_W'(DEPTH) && pop_value == '0, "full error with queue not full")
  `DEQ_ASSERT(a_empty_count, out_valid && empty_error |-> entry_count == '0 && pop_value == '0, "empty error with queue not empty")
  `DEQ_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid, "result shown straight after reset")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pop_value   (pop_value),
  .empty_error (empty_error),
  .full_error  (full_error),
  .entry_count (entry_count)
);

>>> dv/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, clear and unused operations through the valid/ready
// channel and checks every result against a cycle-free deque predictor.
// A short directed table covers the empty and full boundaries, pointer wrap,
// clear and the unused codes. Random bursts that lean towards pushes or
// towards pops then fill and drain the queue under several idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_tb;

  import deq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  // Command codes with no operation behind them
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;

  localparam int ITEMS_PER_PHASE = 140;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    logic              empty_error;
    logic              full_error;
    logic [CNT_W-1:0]  entry_count;
  } deq_result_t;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [DATA_W-1:0] value;
    int                reps;
    bit                has_lit;
    deq_result_t       lit;
  } stim_row_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              out_ready  = 1'b0;
  logic [CMD_W-1:0]  cmd        = '0;
  logic [DATA_W-1:0] push_value = '0;
  logic              in_ready;
  logic              out_valid;
  logic [DATA_W-1:0] pop_value;
  logic              empty_error;
  logic              full_error;
  logic [CNT_W-1:0]  entry_count;

  // Literal expectation travelling alongside the current item
  bit          lit_on  = 1'b0;
  deq_result_t lit_res = '0;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int errors        = 0;

  // Predictor state
  logic [DATA_W-1:0] ring_model [DEPTH];
  logic [PTR_W-1:0]  head_idx;
  logic [PTR_W-1:0]  tail_idx;
  logic [CNT_W-1:0]  fill_level;

  deq_result_t expected_results [$];
  stim_row_t   directed_rows [$];

  double_ended_queue dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pop_value   (pop_value),
    .empty_error (empty_error),
    .full_error  (full_error),
    .entry_count (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the predictor and return the result it causes
  function automatic deq_result_t apply_deque_op(input logic [CMD_W-1:0] op,
                                                 input logic [DATA_W-1:0] value);
    deq_result_t r;
    r = '0;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill_level == CNT_W'(DEPTH)) begin
          r.full_error = 1'b1;
        end else if (op == CMD_PUSH_FRONT) begin
          head_idx = (head_idx == '0) ? PTR_W'(DEPTH - 1) : head_idx - 1'b1;
          ring_model[head_idx] = value;
          fill_level = fill_level + 1'b1;
        end else begin
          ring_model[tail_idx] = value;
          tail_idx = (tail_idx == PTR_W'(DEPTH - 1)) ? '0 : tail_idx + 1'b1;
          fill_level = fill_level + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill_level == '0) begin
          r.empty_error = 1'b1;
        end else if (op == CMD_POP_FRONT) begin
          r.pop_value = ring_model[head_idx];
          head_idx = (head_idx == PTR_W'(DEPTH - 1)) ? '0 : head_idx + 1'b1;
          fill_level = fill_level - 1'b1;
        end else begin
          tail_idx = (tail_idx == '0) ? PTR_W'(DEPTH - 1) : tail_idx - 1'b1;
          r.pop_value = ring_model[tail_idx];
          fill_level = fill_level - 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_idx   = '0;
        tail_idx   = '0;
        fill_level = '0;
      end
      default: ;
    endcase
    r.entry_count = fill_level;
    return r;
  endfunction

  // Predict on acceptance, then check any result taken at this edge
  always @(posedge clk) begin : scoreboard
    deq_result_t want;
    deq_result_t got;
    if (rst) begin
      head_idx   = '0;
      tail_idx   = '0;
      fill_level = '0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        want = apply_deque_op(cmd, push_value);
        if (lit_on) begin
          want = lit_res;
        end
        expected_results.insert(expected_results.size(), want);
      end
      if (out_valid && out_ready) begin
        got = {pop_value, empty_error, full_error, entry_count};
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: pop_value %h count %0d",
                 got.pop_value, got.entry_count);
          errors++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.pop_value !== want.pop_value) begin
            $error("pop_value: expected %h, got %h", want.pop_value, got.pop_value);
            errors++;
          end
          if (got.empty_error !== want.empty_error) begin
            $error("empty_error: expected %b, got %b", want.empty_error,
                   got.empty_error);
            errors++;
          end
          if (got.full_error !== want.full_error) begin
            $error("full_error: expected %b, got %b", want.full_error, got.full_error);
            errors++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   got.entry_count);
            errors++;
          end
        end
      end
    end
  end

  // Stall the result side at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Offer one item, after a random idle gap, and hold it until taken
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value,
                           input bit has_lit, input deq_result_t lit);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    push_value <= value;
    lit_on     <= has_lit;
    lit_res    <= lit;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value,
                         input int reps, input bit has_lit,
                         input logic [DATA_W-1:0] pop, input logic empty,
                         input logic full, input logic [CNT_W-1:0] count);
    stim_row_t row;
    row.op      = op;
    row.value   = value;
    row.reps    = reps;
    row.has_lit = has_lit;
    row.lit     = {pop, empty, full, count};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  initial begin
    int          counted;
    int          burst_len;
    int          k;
    bit          push_heavy;
    int          roll;
    logic [CMD_W-1:0]  op;
    logic [DATA_W-1:0] val;

    // Rows with more than one repeat take a fresh random value each time
    // and are checked by the predictor alone
    add_row(CMD_POP_FRONT,  32'h0,        1,  1, 32'h0,        1'b1, 1'b0, 5'd0);
    add_row(CMD_POP_BACK,   32'h0,        1,  1, 32'h0,        1'b1, 1'b0, 5'd0);
    add_row(CMD_PUSH_FRONT, 32'hFFFFFFFF, 1,  1, 32'h0,        1'b0, 1'b0, 5'd1);
    add_row(CMD_PUSH_BACK,  32'h0,        1,  1, 32'h0,        1'b0, 1'b0, 5'd2);
    add_row(CMD_POP_FRONT,  32'h0,        1,  1, 32'hFFFFFFFF, 1'b0, 1'b0, 5'd1);
    add_row(CMD_POP_BACK,   32'hFFFFFFFF, 1,  1, 32'h0,        1'b0, 1'b0, 5'd0);
    add_row(CMD_UNUSED_A,   32'h0,        1,  1, 32'h0,        1'b0, 1'b0, 5'd0);
    add_row(CMD_UNUSED_C,   32'hFFFFFFFF, 1,  1, 32'h0,        1'b0, 1'b0, 5'd0);
    add_row(CMD_PUSH_BACK,  32'h0,        16, 0, 32'h0,        1'b0, 1'b0, 5'd0);
    add_row(CMD_PUSH_FRONT, 32'hFFFFFFFF, 1,  1, 32'h0,        1'b0, 1'b1, 5'd16);
    add_row(CMD_PUSH_BACK,  32'h0,        1,  1, 32'h0,        1'b0, 1'b1, 5'd16);
    add_row(CMD_UNUSED_B,   32'h0,        1,  1, 32'h0,        1'b0, 1'b0, 5'd16);
    add_row(CMD_POP_FRONT,  32'h0,        2,  0, 32'h0,        1'b0, 1'b0, 5'd0);
    add_row(CMD_POP_BACK,   32'h0,        1,  0, 32'h0,        1'b0, 1'b0, 5'd0);
    add_row(CMD_CLEAR,      32'h0,        1,  1, 32'h0,        1'b0, 1'b0, 5'd0);
    add_row(CMD_POP_BACK,   32'h0,        1,  1, 32'h0,        1'b1, 1'b0, 5'd0);
    add_row(CMD_PUSH_BACK,  32'h5A5A5A5A, 1,  1, 32'h0,        1'b0, 1'b0, 5'd1);
    add_row(CMD_POP_FRONT,  32'h0,        1,  1, 32'h5A5A5A5A, 1'b0, 1'b0, 5'd0);
    add_row(CMD_CLEAR,      32'h0,        1,  1, 32'h0,        1'b0, 1'b0, 5'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table with no idling
    foreach (directed_rows[i]) begin
      for (k = 0; k < directed_rows[i].reps; k++) begin
        val = (directed_rows[i].reps > 1) ? DATA_W'($urandom) : directed_rows[i].value;
        send_item(directed_rows[i].op, val, directed_rows[i].has_lit,
                  directed_rows[i].lit);
      end
    end

    // Random bursts leaning towards fill or drain, one idling pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 61; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 61; end
        default: begin in_idle_pct = 12; out_stall_pct = 12; end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        burst_len  = $urandom_range(24, 8);
        push_heavy = 1'($urandom_range(1));
        for (k = 0; k < burst_len; k++) begin
          roll = $urandom_range(99);
          if (roll < 3) begin
            op = CMD_CLEAR;
          end else if (roll < 6) begin
            op = CMD_W'($urandom_range(CMD_UNUSED_C, CMD_UNUSED_A));
          end else if ($urandom_range(99) < (push_heavy ? 75 : 25)) begin
            op = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
          end else begin
            op = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
          end
          case ($urandom_range(7))
            0:       val = '0;
            1:       val = '1;
            default: val = DATA_W'($urandom);
          endcase
          send_item(op, val, 1'b0, '0);
          if (op <= CMD_CLEAR) begin
            counted++;
          end
        end
      end
    end

    // Drain outstanding results, then watch for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Abandon a hung run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
dv/double_ended_queue_tb.sv
